[rtl/mts_pkg.sv]
// ----------------------------------------------------------------------------
// Melody tone sequencer package
// Shared constants, item codes and the note sounding-time helper.
// ----------------------------------------------------------------------------
`default_nettype none

package mts_pkg;

    // Default sizes, handed to the top level as parameter defaults.
    localparam int SONGS_DEF      = 16;
    localparam int NOTES_DEF      = 64;
    localparam int TONE_CLOCK_DEF = 250000;

    // Field widths.
    localparam int ACT_W    = 3;
    localparam int KEY_W    = 4;
    localparam int NUM_W    = 8;
    localparam int SSLOT_W  = 4;
    localparam int NSLOT_W  = 6;
    localparam int FREQ_W   = 16;
    localparam int TICKS_W  = 8;
    localparam int LEN_W    = 7;
    localparam int CFG_W    = 5;
    localparam int PLAYER_W = 2;
    localparam int NOTE_WORD_W = FREQ_W + TICKS_W;

    // Reset values.
    localparam logic [FREQ_W-1:0] PERIOD_RESET    = 16'd4999;
    localparam logic [CFG_W-1:0]  SONGS_CFG_RESET = 5'd9;
    localparam logic [CFG_W-1:0]  SONGS_SEL_MAX   = 5'd16;
    localparam logic [FREQ_W-1:0] PERIOD_MAX      = 16'hFFFF;

    // Item kinds.
    localparam logic [ACT_W-1:0] ACT_TICK   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_KEY    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REMOTE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_NOTE   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_LEN    = 3'd4;

    // Key codes.
    localparam logic [KEY_W-1:0] KEY_MODE = 4'd11;
    localparam logic [KEY_W-1:0] KEY_PLAY = 4'd15;

    // Mode and player codes.
    localparam logic MODE_MONITOR  = 1'b0;
    localparam logic MODE_PLAYBACK = 1'b1;
    localparam logic [PLAYER_W-1:0] PL_SELECT = 2'd0;
    localparam logic [PLAYER_W-1:0] PL_PLAY   = 2'd1;
    localparam logic [PLAYER_W-1:0] PL_PAUSE  = 2'd2;

    // floor(dur * 0.85): 445655 / 2^19 is 0.85 to within 2e-5, which stays
    // well inside the smallest fractional gap of dur * 0.85 over 8 bits.
    function automatic logic [TICKS_W-1:0] sound_ticks(input logic [TICKS_W-1:0] dur);
        logic [26:0] prod;
        prod = 27'(dur) * 27'(445655);
        return prod[26:19];
    endfunction

endpackage

`default_nettype wire

[rtl/mts_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/mts_div.sv]
// ----------------------------------------------------------------------------
// Tone period divider
// Restoring divider: a fixed tone clock divided by a 16-bit frequency,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_div
    import mts_pkg::*;
#(
    parameter int TONE_CLOCK_HZ = TONE_CLOCK_DEF,
    localparam int QW = $clog2(TONE_CLOCK_HZ + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [FREQ_W-1:0] i_divisor,
    output logic                   o_done,
    output logic      [QW-1:0]     o_quot
);

    localparam int CW = $clog2(QW + 1);
    localparam logic [QW-1:0] DIVIDEND = QW'(TONE_CLOCK_HZ);

    logic              r_busy;
    logic [CW-1:0]     r_cnt;
    logic [FREQ_W-1:0] r_rem;
    logic [FREQ_W-1:0] r_div;
    logic [QW-1:0]     r_quo;
    logic              r_done;

    logic [FREQ_W:0] trial;
    logic            fits;

    assign trial = {r_rem, r_quo[QW-1]};
    assign fits  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW);
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_quo  <= DIVIDEND;
            end else if (r_busy) begin
                // The dividend shifts out of the top as quotient bits enter.
                r_rem <= fits ? FREQ_W'(trial - {1'b0, r_div}) : trial[FREQ_W-1:0];
                r_quo <= {r_quo[QW-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

`default_nettype wire

[rtl/melody_tone_sequencer_top.sv]
// ----------------------------------------------------------------------------
// Melody tone sequencer
// Plays songs from a note memory, driven by ticks, keys, remote selects and
// loads of notes and song lengths.
// ----------------------------------------------------------------------------
// Flow: an item that starts no note passes the EXEC and OUT states into the
//   result register; one that starts a note or a rest also passes FETCH and
//   START, and a sounding note then waits in DIV for the serial divider.
//   One item is in work at a time: no new item is taken until the last one
//   is through, and a stalled output holds it in OUT.
// Reset: control state and length valid bits clear; the note memory is not.
`default_nettype none

module melody_tone_sequencer_top
    import mts_pkg::*;
#(
    parameter int SONGS         = SONGS_DEF,
    parameter int NOTES         = NOTES_DEF,
    parameter int TONE_CLOCK_HZ = TONE_CLOCK_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CFG_W-1:0]    i_cfg_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [ACT_W-1:0]    i_action,
    input  wire logic [KEY_W-1:0]    i_key_code,
    input  wire logic [NUM_W-1:0]    i_song_number,
    input  wire logic [SSLOT_W-1:0]  i_song_slot,
    input  wire logic [NSLOT_W-1:0]  i_note_slot,
    input  wire logic [FREQ_W-1:0]   i_note_freq_hz,
    input  wire logic [TICKS_W-1:0]  i_note_ticks,
    input  wire logic [LEN_W-1:0]    i_song_length,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic                     o_tone_enable,
    output logic      [FREQ_W-1:0]   o_tone_period,
    output logic                     o_mode,
    output logic      [PLAYER_W-1:0] o_player_state,
    output logic      [SSLOT_W-1:0]  o_selected_song,
    output logic      [NSLOT_W-1:0]  o_note_position,
    output logic                     o_display_refresh
);

    localparam int NDEPTH = SONGS * NOTES;
    localparam int NAW    = (NDEPTH > 1) ? $clog2(NDEPTH) : 1;
    localparam int LAW    = (SONGS > 1) ? $clog2(SONGS) : 1;
    localparam int QW     = $clog2(TONE_CLOCK_HZ + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_START = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [CFG_W-1:0]    r_songs_cfg;
    logic                r_mode, n_mode;
    logic [PLAYER_W-1:0] r_player, n_player;
    logic [SSLOT_W-1:0]  r_song, n_song;
    logic [NSLOT_W-1:0]  r_note, n_note;
    logic [TICKS_W-1:0]  r_tick, n_tick;
    logic                r_tone_on, n_tone_on;
    logic [FREQ_W-1:0]   r_period, n_period;
    logic                r_refresh, n_refresh;

    logic [ACT_W-1:0]    r_act;
    logic [KEY_W-1:0]    r_key;
    logic [NUM_W-1:0]    r_num;

    logic [SONGS-1:0]    r_len_vld;
    logic                r_len_hit;
    logic                r_note_ok;

    logic                r_out_valid;
    logic                r_o_tone;
    logic [FREQ_W-1:0]   r_o_period;
    logic                r_o_mode;
    logic [PLAYER_W-1:0] r_o_player;
    logic [SSLOT_W-1:0]  r_o_song;
    logic [NSLOT_W-1:0]  r_o_note;
    logic                r_o_refresh;

    logic                  accept;
    logic                  song_ok, note_ok_now;
    logic [NAW-1:0]        note_raddr, note_waddr;
    logic                  note_we, len_we;
    logic [NOTE_WORD_W-1:0] note_rdata;
    logic [LEN_W-1:0]      len_rdata;
    logic [CFG_W-1:0]      song_limit;

    logic [TICKS_W-1:0]  dur, sound, tick_inc;
    logic [LEN_W-1:0]    slen_raw, slen;
    logic [LEN_W-1:0]    note_inc;
    logic [FREQ_W-1:0]   freq;
    logic                div_start, div_done;
    logic [QW-1:0]       div_quot;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    // ---------------- memories ----------------
    assign song_ok     = (32'(r_song) < SONGS);
    assign note_ok_now = song_ok && (32'(r_note) < NOTES);
    assign note_raddr  = NAW'(r_song) * NAW'(NOTES) + NAW'(r_note);
    assign note_waddr  = NAW'(i_song_slot) * NAW'(NOTES) + NAW'(i_note_slot);
    assign note_we     = accept && (i_action == ACT_NOTE)
                         && (32'(i_song_slot) < SONGS) && (32'(i_note_slot) < NOTES);
    assign len_we      = accept && (i_action == ACT_LEN) && (32'(i_song_slot) < SONGS);

    mts_ram #(
        .WIDTH (NOTE_WORD_W),
        .DEPTH (NDEPTH)
    ) u_note_ram (
        .i_clk   (i_clk),
        .i_we    (note_we),
        .i_waddr (note_waddr),
        .i_wdata ({i_note_ticks, i_note_freq_hz}),
        .i_raddr (note_raddr),
        .o_rdata (note_rdata)
    );

    mts_ram #(
        .WIDTH (LEN_W),
        .DEPTH (SONGS)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (LAW'(i_song_slot)),
        .i_wdata (i_song_length),
        .i_raddr (LAW'(r_song)),
        .o_rdata (len_rdata)
    );

    // A length entry never written reads as zero through its valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_vld <= '0;
            r_len_hit <= 1'b0;
            r_note_ok <= 1'b0;
        end else begin
            if (len_we) begin
                r_len_vld[LAW'(i_song_slot)] <= 1'b1;
            end
            r_len_hit <= song_ok && r_len_vld[LAW'(r_song)];
            r_note_ok <= note_ok_now;
        end
    end

    // ---------------- period divider ----------------
    assign freq      = r_note_ok ? note_rdata[FREQ_W-1:0] : '0;
    assign div_start = (r_state == S_START) && (freq != '0);

    mts_div #(
        .TONE_CLOCK_HZ (TONE_CLOCK_HZ)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_divisor (freq),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    // ---------------- item control ----------------
    assign song_limit = (r_songs_cfg > SONGS_SEL_MAX) ? SONGS_SEL_MAX : r_songs_cfg;
    assign dur        = r_note_ok ? note_rdata[NOTE_WORD_W-1:FREQ_W] : '0;
    assign sound      = sound_ticks(dur);
    assign tick_inc   = r_tick + 1'b1;
    assign slen_raw   = r_len_hit ? len_rdata : '0;
    assign slen       = (32'(slen_raw) > NOTES) ? LEN_W'(NOTES) : slen_raw;
    assign note_inc   = LEN_W'(r_note) + 1'b1;

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_player  = r_player;
        n_song    = r_song;
        n_note    = r_note;
        n_tick    = r_tick;
        n_tone_on = r_tone_on;
        n_period  = r_period;
        n_refresh = r_refresh;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state   = S_EXEC;
                    n_refresh = 1'b0;
                end
            end
            S_EXEC: begin
                n_state = S_OUT;
                case (r_act)
                    ACT_TICK: begin
                        if (r_player == PL_PLAY) begin
                            n_tick = tick_inc;
                            if (tick_inc == sound) begin
                                n_tone_on = 1'b0;
                            end
                            if (tick_inc >= dur) begin
                                n_tick = '0;
                                if (note_inc >= slen) begin
                                    n_note    = '0;
                                    n_player  = PL_SELECT;
                                    n_mode    = MODE_MONITOR;
                                    n_refresh = 1'b1;
                                end else begin
                                    n_note  = NSLOT_W'(note_inc);
                                    n_state = S_FETCH;
                                end
                            end
                        end
                    end
                    ACT_KEY: begin
                        n_refresh = 1'b1;
                        if (r_key == KEY_MODE) begin
                            n_mode    = ~r_mode;
                            n_player  = PL_SELECT;
                            n_tone_on = 1'b0;
                        end else if (r_mode == MODE_PLAYBACK) begin
                            if (r_player == PL_SELECT) begin
                                // A song key wins over start when both could apply.
                                if ((r_key != '0) && ({1'b0, r_key} <= song_limit)) begin
                                    n_song = r_key - 1'b1;
                                end else if (r_key == KEY_PLAY) begin
                                    n_note   = '0;
                                    n_tick   = '0;
                                    n_player = PL_PLAY;
                                    n_state  = S_FETCH;
                                end
                            end else if (r_player == PL_PLAY) begin
                                if (r_key == KEY_PLAY) begin
                                    n_player  = PL_PAUSE;
                                    n_tone_on = 1'b0;
                                end
                            end else begin
                                if (r_key == KEY_PLAY) begin
                                    n_player = PL_PLAY;
                                    n_state  = S_FETCH;
                                end
                            end
                        end
                    end
                    ACT_REMOTE: begin
                        if ((r_num != '0) && (r_num <= NUM_W'(song_limit))) begin
                            n_mode    = MODE_PLAYBACK;
                            n_song    = SSLOT_W'(r_num - 1'b1);
                            n_note    = '0;
                            n_tick    = '0;
                            n_player  = PL_PLAY;
                            n_refresh = 1'b1;
                            n_state   = S_FETCH;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_FETCH: begin
                // The note address now follows the updated song and note.
                n_state = S_START;
            end
            S_START: begin
                if (freq == '0) begin
                    n_tone_on = 1'b0;
                    n_state   = S_OUT;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_tone_on = 1'b1;
                    n_state   = S_OUT;
                    if (div_quot == '0) begin
                        n_period = '0;
                    end else if (32'(div_quot) > 32'd65536) begin
                        n_period = PERIOD_MAX;
                    end else begin
                        n_period = FREQ_W'(div_quot - 1'b1);
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_songs_cfg <= SONGS_CFG_RESET;
            r_mode      <= MODE_MONITOR;
            r_player    <= PL_SELECT;
            r_song      <= '0;
            r_note      <= '0;
            r_tick      <= '0;
            r_tone_on   <= 1'b0;
            r_period    <= PERIOD_RESET;
            r_refresh   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_player  <= n_player;
            r_song    <= n_song;
            r_note    <= n_note;
            r_tick    <= n_tick;
            r_tone_on <= n_tone_on;
            r_period  <= n_period;
            r_refresh <= n_refresh;
            if (i_cfg_we) begin
                r_songs_cfg <= i_cfg_data;
            end
            if ((r_state == S_OUT) && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item payload and the result register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act <= i_action;
            r_key <= i_key_code;
            r_num <= i_song_number;
        end
        if ((r_state == S_OUT) && (!r_out_valid || !i_out_stall)) begin
            r_o_tone    <= r_tone_on;
            r_o_period  <= r_period;
            r_o_mode    <= r_mode;
            r_o_player  <= r_player;
            r_o_song    <= r_song;
            r_o_note    <= r_note;
            r_o_refresh <= r_refresh;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_tone_enable     = r_o_tone;
    assign o_tone_period     = r_o_period;
    assign o_mode            = r_o_mode;
    assign o_player_state    = r_o_player;
    assign o_selected_song   = r_o_song;
    assign o_note_position   = r_o_note;
    assign o_display_refresh = r_o_refresh;

endmodule

`default_nettype wire
